// ===== hdl/rprq_pkg.sv =====
`timescale 1ns / 1ps

package rprq_pkg;

	localparam int IdW   = 16;
	localparam int PrioW = 16;
	localparam int InstW = 31;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_TAKE  = 2'd1;
	localparam logic [1:0] CMD_PEEK  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [InstW-1:0] NO_INSTANT = {InstW{1'b1}};

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic [InstW-1:0] inst;
	} entry_t;

	// table port controls issued by the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_one;
		logic clr_all;
	} tbl_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_FINISH
	} state_t;

endpackage

// ===== hdl/rprq_table.sv =====
`timescale 1ns / 1ps

// Entry store: payload RAM with registered read, valid bits in flops.
module rprq_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rprq_pkg::tbl_ctl_t  ctl,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       clr_addr,
	input  rprq_pkg::entry_t    wr_data,
	output rprq_pkg::entry_t    rd_data,
	output logic                rd_valid
);

	rprq_pkg::entry_t mem [DEPTH];
	rprq_pkg::entry_t rd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_all) begin
				vld_q <= '0;
			end else begin
				if (ctl.wr_en) begin
					vld_q[wr_addr] <= 1'b1;
				end
				if (ctl.clr_one) begin
					vld_q[clr_addr] <= 1'b0;
				end
			end
			if (ctl.rd_en) begin
				rd_valid_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

// ===== hdl/release_priority_ready_queue_core.sv =====
`timescale 1ns / 1ps

// Release-time priority ready queue. Holds up to MAX_ENTRIES activities
// (id, priority, release instant) in a single-port-read RAM plus one valid
// flop per slot. Every command except clear walks the whole table, one slot
// per clock through the RAM read port, and gathers duplicate/free-slot info,
// the best ready entry and the post-command readiness summary in that single
// pass; clear skips the walk. The result sits in an output register, so a
// new command can be accepted in the cycle after the previous one has
// committed, even if its result beat has not yet been taken. A command only
// commits once the previous result beat has been taken. Commands are
// handled one at a time.
module release_priority_ready_queue_core #(
	parameter int MAX_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] activity_id,
	input  logic [15:0] activity_priority,
	input  logic [30:0] release_instant,
	input  logic [30:0] current_instant,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] chosen_id,
	output logic [30:0] chosen_instant,
	output logic        any_ready,
	output logic        any_not_ready,
	output logic [30:0] next_instant,
	output logic [5:0]  entry_count
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int InstW = rprq_pkg::InstW;

	rprq_pkg::state_t state_q, state_d;

	// latched command
	logic [1:0]                   cmd_q;
	logic [rprq_pkg::IdW-1:0]     id_q;
	logic [rprq_pkg::PrioW-1:0]   prio_q;
	logic [InstW-1:0]             rel_q;
	logic [InstW-1:0]             now_q;

	logic [AW-1:0] idx_q;
	logic          issue_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] held_q;

	// scan accumulators
	logic                         dup_q;
	logic                         free_found_q;
	logic [AW-1:0]                free_idx_q;
	logic                         best_found_q;
	logic [AW-1:0]                best_idx_q;
	logic [rprq_pkg::IdW-1:0]     best_id_q;
	logic [rprq_pkg::PrioW-1:0]   best_prio_q;
	logic [InstW-1:0]             best_inst_q;
	logic [1:0]                   rdy_cnt_q;   // saturates at 2
	logic                         wait_q;
	logic [InstW-1:0]             min1_q;
	logic [InstW-1:0]             min2_q;

	// table
	rprq_pkg::tbl_ctl_t tbl_ctl;
	rprq_pkg::entry_t   wr_entry;
	rprq_pkg::entry_t   rd_entry;
	logic               rd_vld;

	logic accept;
	logic commit;
	logic last_issue;

	assign accept     = in_valid && in_ready;
	assign last_issue = (idx_q == AW'(MAX_ENTRIES - 1));

	rprq_table #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.rd_addr  (idx_q),
		.wr_addr  (free_idx_q),
		.clr_addr (best_idx_q),
		.wr_data  (wr_entry),
		.rd_data  (rd_entry),
		.rd_valid (rd_vld)
	);

	assign wr_entry.id   = id_q;
	assign wr_entry.prio = prio_q;
	assign wr_entry.inst = rel_q;

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			rprq_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (cmd == rprq_pkg::CMD_CLEAR) ? rprq_pkg::S_FINISH
					                                       : rprq_pkg::S_SCAN;
				end
			end
			rprq_pkg::S_SCAN: begin
				if (last_issue) begin
					state_d = rprq_pkg::S_LAST;
				end
			end
			rprq_pkg::S_LAST: begin
				state_d = rprq_pkg::S_FINISH;
			end
			rprq_pkg::S_FINISH: begin
				if (!out_valid || out_ready) begin
					state_d = rprq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rprq_pkg::S_IDLE;
			end
		endcase
	end

	// result for the latched command, from the finished accumulators
	logic [1:0]       res_status;
	logic [15:0]      res_id;
	logic [InstW-1:0] res_inst;
	logic             res_ready;
	logic             res_wait;
	logic [InstW-1:0] res_next;
	logic [CW-1:0]    res_held;
	logic             do_write;
	logic             do_remove;

	always_comb begin
		res_status = rprq_pkg::ST_OK;
		res_id     = '0;
		res_inst   = '0;
		res_ready  = (rdy_cnt_q != 2'd0);
		res_wait   = wait_q;
		res_next   = min1_q;
		res_held   = held_q;
		do_write   = 1'b0;
		do_remove  = 1'b0;
		case (cmd_q)
			rprq_pkg::CMD_ADD: begin
				if (dup_q) begin
					res_status = rprq_pkg::ST_DUP;
				end else if (!free_found_q) begin
					res_status = rprq_pkg::ST_FULL;
				end else begin
					do_write = 1'b1;
					res_held = held_q + CW'(1);
					if (rel_q <= now_q) begin
						res_ready = 1'b1;
					end else begin
						res_wait = 1'b1;
					end
					if (rel_q < min1_q) begin
						res_next = rel_q;
					end
				end
			end
			rprq_pkg::CMD_TAKE, rprq_pkg::CMD_PEEK: begin
				if (!best_found_q) begin
					res_status = rprq_pkg::ST_NONE;
				end else begin
					res_id   = best_id_q;
					res_inst = best_inst_q;
					if (cmd_q == rprq_pkg::CMD_TAKE) begin
						do_remove = 1'b1;
						// removing the best ready entry: one fewer ready,
						// and the smallest instant may move to the runner-up
						res_ready = (rdy_cnt_q == 2'd2);
						if (best_inst_q == min1_q) begin
							res_next = min2_q;
						end
						if (held_q != '0) begin
							res_held = held_q - CW'(1);
						end
					end
				end
			end
			rprq_pkg::CMD_CLEAR: begin
				res_ready = 1'b0;
				res_wait  = 1'b0;
				res_next  = rprq_pkg::NO_INSTANT;
				res_held  = '0;
			end
			default: begin
				res_status = rprq_pkg::ST_OK;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready        = (state_q == rprq_pkg::S_IDLE);
		commit          = (state_q == rprq_pkg::S_FINISH) && (!out_valid || out_ready);
		tbl_ctl.rd_en   = (state_q == rprq_pkg::S_SCAN);
		tbl_ctl.wr_en   = commit && do_write;
		tbl_ctl.clr_one = commit && do_remove;
		tbl_ctl.clr_all = commit && (cmd_q == rprq_pkg::CMD_CLEAR);
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rprq_pkg::S_IDLE;
			issue_s1  <= 1'b0;
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= tbl_ctl.rd_en;
			if (commit) begin
				held_q    <= res_held;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// ---------------- scan datapath ----------------
	logic e_ready;
	logic e_better;

	assign e_ready = (rd_entry.inst <= now_q);

	always_comb begin
		if (rd_entry.prio != best_prio_q) begin
			e_better = (rd_entry.prio < best_prio_q);
		end else if (rd_entry.inst != best_inst_q) begin
			e_better = (rd_entry.inst < best_inst_q);
		end else begin
			e_better = (rd_entry.id < best_id_q);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= idx_q;
		if (accept) begin
			cmd_q        <= cmd;
			id_q         <= activity_id;
			prio_q       <= activity_priority;
			rel_q        <= release_instant;
			now_q        <= current_instant;
			idx_q        <= '0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_id_q    <= '0;
			best_prio_q  <= '0;
			best_inst_q  <= '0;
			rdy_cnt_q    <= 2'd0;
			wait_q       <= 1'b0;
			min1_q       <= rprq_pkg::NO_INSTANT;
			min2_q       <= rprq_pkg::NO_INSTANT;
		end else begin
			if (tbl_ctl.rd_en) begin
				idx_q <= idx_q + AW'(1);
			end
			if (issue_s1) begin
				if (rd_vld) begin
					if (rd_entry.id == id_q) begin
						dup_q <= 1'b1;
					end
					if (e_ready) begin
						if (rdy_cnt_q != 2'd2) begin
							rdy_cnt_q <= rdy_cnt_q + 2'd1;
						end
						if (!best_found_q || e_better) begin
							best_found_q <= 1'b1;
							best_idx_q   <= addr_s1;
							best_id_q    <= rd_entry.id;
							best_prio_q  <= rd_entry.prio;
							best_inst_q  <= rd_entry.inst;
						end
					end else begin
						wait_q <= 1'b1;
					end
					// two smallest instants, duplicates counted
					if (rd_entry.inst < min1_q) begin
						min1_q <= rd_entry.inst;
						min2_q <= min1_q;
					end else if (rd_entry.inst < min2_q) begin
						min2_q <= rd_entry.inst;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= addr_s1;
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk) begin
		if (commit) begin
			status         <= res_status;
			chosen_id      <= res_id;
			chosen_instant <= res_inst;
			any_ready      <= res_ready;
			any_not_ready  <= res_wait;
			next_instant   <= res_next;
			entry_count    <= 6'(res_held);
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Checks release_priority_ready_queue_core against a behavioral copy of
// the activity table kept here. Every accepted command beat is run through
// that copy to predict its reply; each reply beat is compared field by field.
module testbench;

	localparam int Slots      = 32;
	// this is many times the slowest legal run of ~830 commands with
	// stalls on both sides
	localparam int CycleLimit = 1_000_000;
	localparam int SettleCyc  = 80;

	// one reply beat as the block presents it
	typedef struct packed {
		logic [1:0]                 status;
		logic [rprq_pkg::IdW-1:0]   chosen_id;
		logic [rprq_pkg::InstW-1:0] chosen_instant;
		logic                       any_ready;
		logic                       any_not_ready;
		logic [rprq_pkg::InstW-1:0] next_instant;
		logic [5:0]                 entry_count;
	} reply_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       cmd = rprq_pkg::CMD_ADD;
	logic [15:0]      activity_id = '0;
	logic [15:0]      activity_priority = '0;
	logic [30:0]      release_instant = '0;
	logic [30:0]      current_instant = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       status;
	logic [15:0]      chosen_id;
	logic [30:0]      chosen_instant;
	logic             any_ready;
	logic             any_not_ready;
	logic [30:0]      next_instant;
	logic [5:0]       entry_count;

	// shadow table: slot contents only matter while the live bit is set
	logic                       tbl_live [Slots] = '{default: 1'b0};
	logic [rprq_pkg::IdW-1:0]   tbl_id   [Slots];
	logic [rprq_pkg::PrioW-1:0] tbl_prio [Slots];
	logic [rprq_pkg::InstW-1:0] tbl_inst [Slots];
	int                         tbl_count = 0;

	reply_t           reply_q [$];
	reply_t           got_want;
	int               fail_count = 0;
	int               cycles = 0;
	int               gap_pct = 0;    // chance per cycle that the sender idles
	int               stall_pct = 0;  // chance per cycle that the receiver stalls

	release_priority_ready_queue_core #(
		.MAX_ENTRIES(Slots)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.activity_id(activity_id),
		.activity_priority(activity_priority),
		.release_instant(release_instant),
		.current_instant(current_instant),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chosen_id(chosen_id),
		.chosen_instant(chosen_instant),
		.any_ready(any_ready),
		.any_not_ready(any_not_ready),
		.next_instant(next_instant),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Apply one command to the shadow table and return the reply it should
	// produce. Flags, next instant and count are taken after the command.
	function automatic reply_t run_queue_cmd(logic [1:0] op, logic [15:0] aid,
			logic [15:0] aprio, logic [30:0] rel, logic [30:0] now);
		reply_t r;
		int     i;
		int     free_slot;
		int     pick;
		bit     dup;
		r = '0;
		r.status = rprq_pkg::ST_OK;
		r.next_instant = rprq_pkg::NO_INSTANT;
		free_slot = -1;
		pick = -1;
		dup = 1'b0;
		case (op)
		rprq_pkg::CMD_ADD: begin
			for (i = 0; i < Slots; i++) begin
				if (tbl_live[i]) begin
					if (tbl_id[i] == aid)
						dup = 1'b1;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			// duplicate wins over full
			if (dup) begin
				r.status = rprq_pkg::ST_DUP;
			end else if (free_slot < 0) begin
				r.status = rprq_pkg::ST_FULL;
			end else begin
				tbl_live[free_slot] = 1'b1;
				tbl_id[free_slot] = aid;
				tbl_prio[free_slot] = aprio;
				tbl_inst[free_slot] = rel;
				tbl_count++;
			end
		end
		rprq_pkg::CMD_CLEAR: begin
			for (i = 0; i < Slots; i++)
				tbl_live[i] = 1'b0;
			tbl_count = 0;
		end
		default: begin
			// best ready entry: lowest priority, then earliest instant, then lowest id
			for (i = 0; i < Slots; i++) begin
				if (tbl_live[i] && tbl_inst[i] <= now) begin
					if (pick < 0)
						pick = i;
					else if (tbl_prio[i] != tbl_prio[pick] ? tbl_prio[i] < tbl_prio[pick] :
							tbl_inst[i] != tbl_inst[pick] ? tbl_inst[i] < tbl_inst[pick] :
							tbl_id[i] < tbl_id[pick])
						pick = i;
				end
			end
			if (pick < 0) begin
				r.status = rprq_pkg::ST_NONE;
			end else begin
				r.chosen_id = tbl_id[pick];
				r.chosen_instant = tbl_inst[pick];
				if (op == rprq_pkg::CMD_TAKE) begin
					tbl_live[pick] = 1'b0;
					tbl_count--;
				end
			end
		end
		endcase
		for (i = 0; i < Slots; i++) begin
			if (tbl_live[i]) begin
				if (tbl_inst[i] <= now)
					r.any_ready = 1'b1;
				else
					r.any_not_ready = 1'b1;
				if (tbl_inst[i] < r.next_instant)
					r.next_instant = tbl_inst[i];
			end
		end
		r.entry_count = 6'(tbl_count);
		return r;
	endfunction

	// Drive one command beat, hold it until accepted, then log its reply.
	// Valid stays high into the next call unless that call idles first.
	task automatic send_cmd(logic [1:0] op, logic [15:0] aid, logic [15:0] aprio,
			logic [30:0] rel, logic [30:0] now);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		activity_id <= aid;
		activity_priority <= aprio;
		release_instant <= rel;
		current_instant <= now;
		do
			@(posedge clk);
		while (!in_ready);
		reply_q.push_back(run_queue_cmd(op, aid, aprio, rel, now));
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// reply beat checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (reply_q.size() == 0) begin
				$error("reply beat with no command outstanding");
				fail_count++;
			end else begin
				got_want = reply_q.pop_front();
				check_field("status", 32'(got_want.status), 32'(status));
				check_field("chosen_id", 32'(got_want.chosen_id), 32'(chosen_id));
				check_field("chosen_instant", 32'(got_want.chosen_instant),
					32'(chosen_instant));
				check_field("any_ready", 32'(got_want.any_ready), 32'(any_ready));
				check_field("any_not_ready", 32'(got_want.any_not_ready),
					32'(any_not_ready));
				check_field("next_instant", 32'(got_want.next_instant),
					32'(next_instant));
				check_field("entry_count", 32'(got_want.entry_count), 32'(entry_count));
			end
		end
	end

	// time window anchor: near zero, near the top, or anywhere
	function automatic logic [30:0] pick_base();
		case ($urandom_range(3))
		0: return '0;
		1: return rprq_pkg::NO_INSTANT - 31'd15;
		default: return 31'($urandom);
		endcase
	endfunction

	// mostly a narrow window so ready/not-ready mixes and instant ties happen
	function automatic logic [30:0] pick_instant(logic [30:0] base);
		logic [31:0] t;
		if ($urandom_range(7) == 0)
			return 31'($urandom);
		t = {1'b0, base} + $urandom_range(15);
		return (t > {1'b0, rprq_pkg::NO_INSTANT}) ? rprq_pkg::NO_INSTANT : t[30:0];
	endfunction

	// small pool half the time so duplicates and id ties show up
	function automatic logic [15:0] pick_id();
		return $urandom_range(1) ? 16'($urandom_range(15)) : 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_prio();
		return $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
	endfunction

	// take/peek on an empty table, clear on an empty table
	task automatic test_empty_table();
		send_cmd(rprq_pkg::CMD_PEEK, 16'hFFFF, 16'hFFFF, rprq_pkg::NO_INSTANT, '0);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, rprq_pkg::NO_INSTANT);
		send_cmd(rprq_pkg::CMD_CLEAR, '0, '0, '0, '0);
	endtask

	// field extremes, duplicate refusal, not-ready entries, entry at top instant
	task automatic test_extremes();
		send_cmd(rprq_pkg::CMD_ADD, 16'h0000, 16'h0000, '0, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, rprq_pkg::NO_INSTANT, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'h0001, 16'hFFFF, rprq_pkg::NO_INSTANT,
			rprq_pkg::NO_INSTANT);
		send_cmd(rprq_pkg::CMD_ADD, 16'h0000, 16'h1234, 31'd5, '0);
		send_cmd(rprq_pkg::CMD_PEEK, '0, '0, '0, '0);
		send_cmd(rprq_pkg::CMD_PEEK, '0, '0, '0, rprq_pkg::NO_INSTANT - 31'd1);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, '0);
		// remaining two sit at the top instant: nothing ready below it
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, '0);
		send_cmd(rprq_pkg::CMD_PEEK, '0, '0, '0, rprq_pkg::NO_INSTANT);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, rprq_pkg::NO_INSTANT);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, rprq_pkg::NO_INSTANT);
	endtask

	// priority first, then earlier instant, then lower id
	task automatic test_tie_breaks();
		send_cmd(rprq_pkg::CMD_CLEAR, '0, '0, '0, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'd5, 16'd7, 31'd50, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'd3, 16'd7, 31'd100, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'd9, 16'd6, 31'd200, '0);
		send_cmd(rprq_pkg::CMD_ADD, 16'd4, 16'd7, 31'd50, '0);
		send_cmd(rprq_pkg::CMD_PEEK, '0, '0, '0, 31'd150);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, 31'd250);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, 31'd250);
		send_cmd(rprq_pkg::CMD_TAKE, '0, '0, '0, 31'd250);
	endtask

	// clear, fill past capacity, duplicate on a full table, then drain
	task automatic test_fill_and_drain();
		logic [30:0] base;
		int          i;
		int          k;
		base = pick_base();
		send_cmd(rprq_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 31'($urandom),
			31'($urandom));
		for (i = 0; i < Slots + 2; i++)
			send_cmd(rprq_pkg::CMD_ADD, 16'($urandom), pick_prio(), pick_instant(base),
				pick_instant(base));
		do
			k = $urandom_range(Slots - 1);
		while (!tbl_live[k]);
		send_cmd(rprq_pkg::CMD_ADD, tbl_id[k], pick_prio(), pick_instant(base),
			pick_instant(base));
		for (i = 0; i < Slots + 4; i++)
			send_cmd($urandom_range(3) == 0 ? rprq_pkg::CMD_PEEK : rprq_pkg::CMD_TAKE,
				pick_id(), pick_prio(), pick_instant(base),
				$urandom_range(3) == 0 ? rprq_pkg::NO_INSTANT : pick_instant(base));
	endtask

	// weighted mix of all commands with random content
	task automatic test_random_mix(int n);
		logic [30:0] base;
		logic [1:0]  op;
		int          roll;
		base = pick_base();
		repeat (n) begin
			if ($urandom_range(39) == 0)
				base = pick_base();
			roll = $urandom_range(99);
			op = roll < 45 ? rprq_pkg::CMD_ADD :
				roll < 72 ? rprq_pkg::CMD_TAKE :
				roll < 97 ? rprq_pkg::CMD_PEEK : rprq_pkg::CMD_CLEAR;
			send_cmd(op, pick_id(), pick_prio(), pick_instant(base), pick_instant(base));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extremes();
		test_tie_breaks();

		// steady flow on both sides
		test_fill_and_drain();
		test_random_mix(130);
		// sparse sender
		gap_pct = 69;
		stall_pct = 0;
		test_fill_and_drain();
		test_random_mix(130);
		// slow receiver
		gap_pct = 0;
		stall_pct = 69;
		test_fill_and_drain();
		test_random_mix(130);
		// both sides idle
		gap_pct = 37;
		stall_pct = 37;
		test_fill_and_drain();
		test_random_mix(130);

		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		// catch any stray reply beat
		repeat (SettleCyc) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
